// File: hw/rtl/trm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trm_pkg
// Shared types and constants for the token/request matcher.
// ----------------------------------------------------------------------------
package trm_pkg;

  localparam int PeerCount  = 8;
  localparam int PeerScan   = 255;
  localparam int TokenSlots = 16;
  localparam int NamedSlots = 16;
  localparam int AnySlots   = 16;
  localparam int TokW = $clog2(TokenSlots);
  localparam int NamW = $clog2(NamedSlots);
  localparam int AnyW = $clog2(AnySlots);

  typedef enum logic [1:0] {
    FUNC_NAMED = 2'd0,
    FUNC_ANY   = 2'd1,
    FUNC_TOKEN = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    OUT_DISPATCH = 2'd0,
    OUT_REQ_HELD = 2'd1,
    OUT_TOK_HELD = 2'd2,
    OUT_DROPPED  = 2'd3
  } outcome_e;

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] peer;
    logic [7:0] protocol;
    logic [7:0] sequence_number;
    logic [7:0] request_tag;
  } item_t;

  typedef struct packed {
    logic [1:0] outcome;
    logic [7:0] out_tag;
    logic [2:0] out_peer;
    logic [7:0] out_protocol;
    logic [7:0] out_sequence;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture the input beat
    logic commit; // search result applied to the stores
  } trm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic valid_func;
  } trm_sts_t;

endpackage
`default_nettype wire

// File: hw/rtl/token_request_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// From input beat to result beat: capture, then search and commit.
// A new item is taken only once the previous one is finished; single search/compaction stage.
// A func 3 beat produces no result.
// Reset (rst_ni low, asynchronous) empties all three stores at once.
// ----------------------------------------------------------------------------
// token_request_matcher
// Matches receive requests against arrived control tokens.
// ----------------------------------------------------------------------------
module token_request_matcher (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_tvalid_i,
  output logic        s_tready_o,
  input  wire  [31:0] s_tdata_i,  // func, peer, protocol, sequence_number, request_tag, pad
  output logic        m_tvalid_o,
  input  wire         m_tready_i,
  output logic [31:0] m_tdata_o   // outcome, out_tag, out_peer, out_protocol, out_sequence, pad
);
  import trm_pkg::*;

  item_t     item;
  result_t   res;
  trm_cmd_t  cmd;
  trm_sts_t  sts;

  assign item.func            = s_tdata_i[1:0];
  assign item.peer            = s_tdata_i[4:2];
  assign item.protocol        = s_tdata_i[12:5];
  assign item.sequence_number = s_tdata_i[20:13];
  assign item.request_tag     = s_tdata_i[28:21];

  assign m_tdata_o = {3'b000, res.out_sequence, res.out_protocol, res.out_peer,
                      res.out_tag, res.outcome};

  trm_ctrl u_ctrl (
    .clk_i, .rst_ni, .s_tvalid_i, .s_tready_o, .m_tvalid_o, .m_tready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  trm_datapath u_dp (
    .clk_i, .rst_ni, .item_i(item), .cmd_i(cmd), .sts_o(sts), .res_o(res)
  );

endmodule
`default_nettype wire

// File: hw/rtl/trm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trm_datapath
// Three ordered stores with parallel compare, priority pick and compaction.
// ----------------------------------------------------------------------------
module trm_datapath (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  trm_pkg::item_t      item_i,
  input  trm_pkg::trm_cmd_t   cmd_i,
  output trm_pkg::trm_sts_t   sts_o,
  output trm_pkg::result_t    res_o
);
  import trm_pkg::*;

  item_t it_q;

  logic [2:0] tk_peer_q [TokenSlots];
  logic [7:0] tk_pro_q  [TokenSlots];
  logic [7:0] tk_seq_q  [TokenSlots];
  logic [TokW:0] tk_cnt_q;

  logic [2:0] nm_peer_q [NamedSlots];
  logic [7:0] nm_pro_q  [NamedSlots];
  logic [7:0] nm_seq_q  [NamedSlots];
  logic [7:0] nm_tag_q  [NamedSlots];
  logic [NamW:0] nm_cnt_q;

  logic [7:0] an_pro_q [AnySlots];
  logic [7:0] an_seq_q [AnySlots];
  logic [7:0] an_tag_q [AnySlots];
  logic [AnyW:0] an_cnt_q;

  logic [TokenSlots-1:0] tk_hit_named, tk_hit_any;
  logic [NamedSlots-1:0] nm_hit;
  logic [AnySlots-1:0]   an_hit;

  always_comb begin
    for (int i = 0; i < TokenSlots; i++) begin
      tk_hit_named[i] = (i < tk_cnt_q) && tk_peer_q[i] == it_q.peer &&
                        tk_pro_q[i] == it_q.protocol && tk_seq_q[i] == it_q.sequence_number;
      tk_hit_any[i] = (i < tk_cnt_q) && (int'(tk_peer_q[i]) < PeerCount) &&
                      (int'(tk_peer_q[i]) < PeerScan) &&
                      tk_pro_q[i] == it_q.protocol && tk_seq_q[i] == it_q.sequence_number;
    end
    for (int i = 0; i < NamedSlots; i++)
      nm_hit[i] = (i < nm_cnt_q) && nm_peer_q[i] == it_q.peer &&
                  nm_pro_q[i] == it_q.protocol && nm_seq_q[i] == it_q.sequence_number;
    for (int i = 0; i < AnySlots; i++)
      an_hit[i] = (i < an_cnt_q) && an_pro_q[i] == it_q.protocol &&
                  an_seq_q[i] == it_q.sequence_number;
  end

  // oldest named hit
  logic tn_f; logic [TokW-1:0] tn_idx;
  always_comb begin
    tn_f = 1'b0; tn_idx = '0;
    for (int i = TokenSlots-1; i >= 0; i--)
      if (tk_hit_named[i]) begin tn_f = 1'b1; tn_idx = TokW'(i); end
  end

  // lowest peer, then oldest
  logic ta_f; logic [TokW-1:0] ta_idx; logic [2:0] ta_peer;
  always_comb begin
    ta_f = 1'b0; ta_idx = '0; ta_peer = '0;
    for (int i = 0; i < TokenSlots; i++)
      if (tk_hit_any[i] && (!ta_f || tk_peer_q[i] < ta_peer)) begin
        ta_f = 1'b1; ta_idx = TokW'(i); ta_peer = tk_peer_q[i];
      end
  end

  logic nm_f; logic [NamW-1:0] nm_idx;
  always_comb begin
    nm_f = 1'b0; nm_idx = '0;
    for (int i = NamedSlots-1; i >= 0; i--)
      if (nm_hit[i]) begin nm_f = 1'b1; nm_idx = NamW'(i); end
  end

  logic an_f; logic [AnyW-1:0] an_idx;
  always_comb begin
    an_f = 1'b0; an_idx = '0;
    for (int i = AnySlots-1; i >= 0; i--)
      if (an_hit[i]) begin an_f = 1'b1; an_idx = AnyW'(i); end
  end

  // decision
  logic tk_rm, tk_add, nm_rm, nm_add, an_rm, an_add;
  logic [TokW-1:0] tk_rm_idx;
  result_t res_d;
  always_comb begin
    tk_rm = 1'b0; tk_add = 1'b0; nm_rm = 1'b0; nm_add = 1'b0;
    an_rm = 1'b0; an_add = 1'b0; tk_rm_idx = tn_idx;
    res_d.outcome      = OUT_DROPPED;
    res_d.out_tag      = it_q.request_tag;
    res_d.out_peer     = it_q.peer;
    res_d.out_protocol = it_q.protocol;
    res_d.out_sequence = it_q.sequence_number;
    case (func_e'(it_q.func))
      FUNC_NAMED: begin
        if (tn_f) begin
          tk_rm = 1'b1; res_d.outcome = OUT_DISPATCH;
        end else if (nm_cnt_q < (NamW+1)'(NamedSlots)) begin
          nm_add = 1'b1; res_d.outcome = OUT_REQ_HELD;
        end
      end
      FUNC_ANY: begin
        if (ta_f) begin
          tk_rm = 1'b1; tk_rm_idx = ta_idx;
          res_d.outcome = OUT_DISPATCH; res_d.out_peer = ta_peer;
        end else begin
          res_d.out_peer = '0;
          if (an_cnt_q < (AnyW+1)'(AnySlots)) begin
            an_add = 1'b1; res_d.outcome = OUT_REQ_HELD;
          end
        end
      end
      FUNC_TOKEN: begin
        if (an_f) begin
          an_rm = 1'b1; res_d.outcome = OUT_DISPATCH; res_d.out_tag = an_tag_q[an_idx];
        end else if (nm_f) begin
          nm_rm = 1'b1; res_d.outcome = OUT_DISPATCH; res_d.out_tag = nm_tag_q[nm_idx];
        end else begin
          res_d.out_tag = '0;
          if (tk_cnt_q < (TokW+1)'(TokenSlots)) begin
            tk_add = 1'b1; res_d.outcome = OUT_TOK_HELD;
          end
        end
      end
      default: ;
    endcase
  end

  assign sts_o.valid_func = (it_q.func != FUNC_NONE);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) it_q <= item_i;
    if (cmd_i.commit) res_o <= res_d;
  end

  // stores: compaction on removal, append at count
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (tk_rm)
        for (int i = 0; i < TokenSlots-1; i++)
          if (TokW'(i) >= tk_rm_idx) begin
            tk_peer_q[i] <= tk_peer_q[i+1];
            tk_pro_q[i]  <= tk_pro_q[i+1];
            tk_seq_q[i]  <= tk_seq_q[i+1];
          end
      if (tk_add) begin
        tk_peer_q[tk_cnt_q[TokW-1:0]] <= it_q.peer;
        tk_pro_q[tk_cnt_q[TokW-1:0]]  <= it_q.protocol;
        tk_seq_q[tk_cnt_q[TokW-1:0]]  <= it_q.sequence_number;
      end
      if (nm_rm)
        for (int i = 0; i < NamedSlots-1; i++)
          if (NamW'(i) >= nm_idx) begin
            nm_peer_q[i] <= nm_peer_q[i+1];
            nm_pro_q[i]  <= nm_pro_q[i+1];
            nm_seq_q[i]  <= nm_seq_q[i+1];
            nm_tag_q[i]  <= nm_tag_q[i+1];
          end
      if (nm_add) begin
        nm_peer_q[nm_cnt_q[NamW-1:0]] <= it_q.peer;
        nm_pro_q[nm_cnt_q[NamW-1:0]]  <= it_q.protocol;
        nm_seq_q[nm_cnt_q[NamW-1:0]]  <= it_q.sequence_number;
        nm_tag_q[nm_cnt_q[NamW-1:0]]  <= it_q.request_tag;
      end
      if (an_rm)
        for (int i = 0; i < AnySlots-1; i++)
          if (AnyW'(i) >= an_idx) begin
            an_pro_q[i] <= an_pro_q[i+1];
            an_seq_q[i] <= an_seq_q[i+1];
            an_tag_q[i] <= an_tag_q[i+1];
          end
      if (an_add) begin
        an_pro_q[an_cnt_q[AnyW-1:0]] <= it_q.protocol;
        an_seq_q[an_cnt_q[AnyW-1:0]] <= it_q.sequence_number;
        an_tag_q[an_cnt_q[AnyW-1:0]] <= it_q.request_tag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tk_cnt_q <= '0; nm_cnt_q <= '0; an_cnt_q <= '0;
    end else if (cmd_i.commit) begin
      if (tk_rm) tk_cnt_q <= tk_cnt_q - 1'b1;
      else if (tk_add) tk_cnt_q <= tk_cnt_q + 1'b1;
      if (nm_rm) nm_cnt_q <= nm_cnt_q - 1'b1;
      else if (nm_add) nm_cnt_q <= nm_cnt_q + 1'b1;
      if (an_rm) an_cnt_q <= an_cnt_q - 1'b1;
      else if (an_add) an_cnt_q <= an_cnt_q + 1'b1;
    end
  end

  a_tk_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tk_cnt_q <= (TokW+1)'(TokenSlots)) else $error("token count overflow");
  a_nm_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nm_cnt_q <= (NamW+1)'(NamedSlots)) else $error("named count overflow");
  a_an_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    an_cnt_q <= (AnyW+1)'(AnySlots)) else $error("any count overflow");
  a_one_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> $countones({tk_rm, tk_add, nm_rm, nm_add, an_rm, an_add}) <= 1)
    else $error("more than one store touched");

endmodule
`default_nettype wire

// File: hw/rtl/trm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trm_ctrl
// Handshake sequencer: take beat, search and commit, present result unless func is none.
// ----------------------------------------------------------------------------
module trm_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_tvalid_i,
  output logic                s_tready_o,
  output logic                m_tvalid_o,
  input  wire                 m_tready_i,
  input  trm_pkg::trm_sts_t   sts_i,
  output trm_pkg::trm_cmd_t   cmd_o
);
  import trm_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_OUT} state_e;
  state_e state_q;

  assign s_tready_o  = (state_q == ST_IDLE);
  assign m_tvalid_o  = (state_q == ST_OUT);
  assign cmd_o.load   = s_tready_o && s_tvalid_i;
  assign cmd_o.commit = (state_q == ST_EXEC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: if (s_tvalid_i) state_q <= ST_EXEC;
        ST_EXEC: state_q <= sts_i.valid_func ? ST_OUT : ST_IDLE;
        ST_OUT:  if (m_tready_i) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> !s_tready_o) else $error("input taken while result pending");
  a_exec_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> !cmd_o.commit) else $error("double commit");
  a_load_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.commit) else $error("load not followed by commit");

endmodule
`default_nettype wire
